// File: rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and helpers for the quaternion to euler angle block.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QTE_COMP_BITS = 16;
    localparam int QTE_COMP_DROP = (QTE_COMP_BITS > 16) ? (QTE_COMP_BITS - 16) : 0;
    localparam int QTE_CORDIC_STAGES_DEF = 16;

    // atan2 operand width, CORDIC datapath width, normalized leading-one position
    localparam int QTE_AW = 36;
    localparam int QTE_CW = 44;
    localparam int QTE_NORM_BIT = 40;

    localparam logic [15:0] QTE_THR_RST = 16'd32703;
    localparam logic [31:0] QTE_PI_ANGLE = 32'h8000_0000;
    localparam logic signed [15:0] QTE_HALF_PI = 16'sd16384;
    localparam logic signed [15:0] QTE_NEG_HALF_PI = -16'sd16384;

    localparam logic [31:0] QTE_ATAN_LUT [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2,
        POLE_ZERO  = 2'd3
    } t_pole_status;

    typedef struct packed {
        logic signed [QTE_COMP_BITS-1:0] quat_w;
        logic signed [QTE_COMP_BITS-1:0] quat_x;
        logic signed [QTE_COMP_BITS-1:0] quat_y;
        logic signed [QTE_COMP_BITS-1:0] quat_z;
    } t_qte_in;

    typedef struct packed {
        logic signed [15:0] bank_angle;
        logic signed [15:0] heading_angle;
        logic signed [15:0] attitude_angle;
        t_pole_status       pole_status;
    } t_qte_out;

    // 32-bit binary angle to 16 bits, round half up, wrapping
    function automatic logic [15:0] qte_angle_out(input logic [31:0] a);
        logic [31:0] t;
        t = a + 32'h0000_8000;
        return t[31:16];
    endfunction

endpackage

// File: rtl/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2
// Pipelined atan2: normalize stage, quadrant fold stage, one vectoring CORDIC
// iteration per register stage; advances on i_en.
// ----------------------------------------------------------------------------
module qte_atan2 #(
    parameter int STAGES = qte_pkg::QTE_CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [qte_pkg::QTE_AW-1:0] i_y,
    input  logic signed [qte_pkg::QTE_AW-1:0] i_x,
    output logic [31:0]                      o_angle
);
    import qte_pkg::*;

    logic [QTE_AW-1:0] mag_x, mag_y, mag_or;
    logic [5:0]        msb;

    logic signed [QTE_AW-1:0] r_a_x, r_a_y;
    logic [5:0]               r_a_sh;
    logic                     r_a_zero;

    logic signed [QTE_CW-1:0] n_b_x, n_b_y;
    logic [31:0]              n_b_ang;

    logic signed [QTE_CW-1:0] r_cx [0:STAGES];
    logic signed [QTE_CW-1:0] r_cy [0:STAGES];
    logic [31:0]              r_ca [0:STAGES];
    logic                     r_cz [0:STAGES];

    // leading one of the larger magnitude
    always_comb begin
        mag_x  = i_x[QTE_AW-1] ? QTE_AW'(-i_x) : QTE_AW'(i_x);
        mag_y  = i_y[QTE_AW-1] ? QTE_AW'(-i_y) : QTE_AW'(i_y);
        mag_or = mag_x | mag_y;
        msb    = '0;
        for (int i = 0; i < QTE_AW; i++) begin
            if (mag_or[i]) msb = 6'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= i_x;
            r_a_y    <= i_y;
            r_a_sh   <= 6'(QTE_NORM_BIT) - msb;
            r_a_zero <= (mag_or == '0);
        end
    end

    // exact scale so the larger magnitude lands in [2^40, 2^41), then fold left half
    always_comb begin
        n_b_x   = QTE_CW'(r_a_x) <<< r_a_sh;
        n_b_y   = QTE_CW'(r_a_y) <<< r_a_sh;
        n_b_ang = '0;
        if (n_b_x < 0) begin
            n_b_x   = -n_b_x;
            n_b_y   = -n_b_y;
            n_b_ang = QTE_PI_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= n_b_x;
            r_cy[0] <= n_b_y;
            r_ca[0] <= n_b_ang;
            r_cz[0] <= r_a_zero;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_iter
        localparam int S = g % 32;
        logic signed [QTE_CW-1:0] dx, dy;
        assign dx = r_cy[g] >>> S;
        assign dy = r_cx[g] >>> S;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[g][QTE_CW-1]) begin
                    r_cx[g+1] <= r_cx[g] + dx;
                    r_cy[g+1] <= r_cy[g] - dy;
                    r_ca[g+1] <= r_ca[g] + QTE_ATAN_LUT[S];
                end else begin
                    r_cx[g+1] <= r_cx[g] - dx;
                    r_cy[g+1] <= r_cy[g] + dy;
                    r_ca[g+1] <= r_ca[g] - QTE_ATAN_LUT[S];
                end
                r_cz[g+1] <= r_cz[g];
            end
        end
    end

    assign o_angle = r_cz[STAGES] ? 32'd0 : r_ca[STAGES];

endmodule

// File: rtl/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Quaternion (Q1.15, any norm) to bank, heading and attitude binary angles.
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion is taken every cycle while no result waits
// on an output stall. The pipeline holds five product and pole-test stages,
// a 32-stage integer square root feeding the attitude atan2, and
// CORDIC_STAGES+2 stages in each atan2 unit; bank and heading are delayed
// to line up with attitude. A stall on the output freezes the whole
// pipeline, so input stall is high exactly while a result waits.
module quaternion_to_euler_angles_top #(
    parameter int CORDIC_STAGES = qte_pkg::QTE_CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  qte_pkg::t_qte_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output qte_pkg::t_qte_out o_out_data
);
    import qte_pkg::*;

    localparam int LAT_CORDIC = CORDIC_STAGES + 2;
    localparam int SQRT_STEPS = 32;
    localparam int DLY = SQRT_STEPS + 1;
    localparam int NSTG = 39 + LAT_CORDIC;

    logic        en;
    logic [15:0] r_thr;
    logic [NSTG:1] r_vld;

    // stage 1: components
    logic signed [31:0] ext_w, ext_x, ext_y, ext_z;
    logic signed [15:0] r1_w, r1_x, r1_y, r1_z;
    // stage 2: products
    logic signed [31:0] r2_ww, r2_xx, r2_yy, r2_zz, r2_xy, r2_zw, r2_yw, r2_xz, r2_xw, r2_yz;
    logic signed [15:0] r2_w, r2_x;
    // stage 3: sums
    logic signed [34:0] r3_unit, r3_test, r3_ha, r3_hb, r3_bb, r3_ba;
    logic signed [15:0] r3_w, r3_x;
    // stage 4
    logic [48:0]        r4_lim;
    logic signed [49:0] r4_scaled;
    logic               r4_zero;
    logic [34:0]        abs_ha, abs_hb;
    logic [31:0]        r4_a2, r4_b2;
    logic signed [34:0] r4_test, r4_ha, r4_hb, r4_bb, r4_ba;
    logic signed [15:0] r4_w, r4_x;
    // stage 5
    logic signed [49:0] lim_s;
    t_pole_status       n5_sts, r5_sts;
    logic [63:0]        r5_a2sq, r5_b2sq;
    logic signed [34:0] r5_test, r5_ha, r5_hb, r5_bb, r5_ba;
    logic signed [15:0] r5_w, r5_x;
    logic               pole5;
    // square root line, index 0 is stage 6
    logic [63:0]        r_sv [0:SQRT_STEPS];
    logic [63:0]        r_sr [0:SQRT_STEPS];
    logic signed [34:0] r_st [0:SQRT_STEPS];
    // alignment lines
    t_pole_status       r_sts_line [1:DLY+LAT_CORDIC];
    logic [31:0]        r_bank_line [1:DLY];
    logic [31:0]        r_head_line [1:DLY];

    logic [31:0] bank_ang, head_ang, att_ang, twice;
    logic signed [15:0] att16;
    t_pole_status sts_out;
    t_qte_out     r_out;

    assign en          = !r_vld[NSTG] || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[NSTG];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= QTE_THR_RST;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            if (en) r_vld <= {r_vld[NSTG-1:1], i_in_valid};
        end
    end

    // wider components keep their top 16 bits
    assign ext_w = (32'(i_in_data.quat_w)) >>> QTE_COMP_DROP;
    assign ext_x = (32'(i_in_data.quat_x)) >>> QTE_COMP_DROP;
    assign ext_y = (32'(i_in_data.quat_y)) >>> QTE_COMP_DROP;
    assign ext_z = (32'(i_in_data.quat_z)) >>> QTE_COMP_DROP;

    always_comb begin
        abs_ha = r3_ha[34] ? 35'(-r3_ha) : 35'(r3_ha);
        abs_hb = r3_hb[34] ? 35'(-r3_hb) : 35'(r3_hb);
        lim_s  = signed'({1'b0, r4_lim});
        priority if (r4_zero)            n5_sts = POLE_ZERO;
        else if (r4_scaled > lim_s)      n5_sts = POLE_NORTH;
        else if (r4_scaled < -lim_s)     n5_sts = POLE_SOUTH;
        else                             n5_sts = POLE_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_w <= ext_w[15:0];
            r1_x <= ext_x[15:0];
            r1_y <= ext_y[15:0];
            r1_z <= ext_z[15:0];

            r2_ww <= 32'(r1_w * r1_w);
            r2_xx <= 32'(r1_x * r1_x);
            r2_yy <= 32'(r1_y * r1_y);
            r2_zz <= 32'(r1_z * r1_z);
            r2_xy <= 32'(r1_x * r1_y);
            r2_zw <= 32'(r1_z * r1_w);
            r2_yw <= 32'(r1_y * r1_w);
            r2_xz <= 32'(r1_x * r1_z);
            r2_xw <= 32'(r1_x * r1_w);
            r2_yz <= 32'(r1_y * r1_z);
            r2_w  <= r1_w;
            r2_x  <= r1_x;

            r3_unit <= 35'(r2_ww) + 35'(r2_xx) + 35'(r2_yy) + 35'(r2_zz);
            r3_test <= 35'(r2_xy) + 35'(r2_zw);
            r3_ha   <= 35'(r2_xx) - 35'(r2_yy) - 35'(r2_zz) + 35'(r2_ww);
            r3_hb   <= (35'(r2_yw) - 35'(r2_xz)) <<< 1;
            r3_bb   <= (35'(r2_xw) - 35'(r2_yz)) <<< 1;
            r3_ba   <= 35'(r2_yy) - 35'(r2_xx) - 35'(r2_zz) + 35'(r2_ww);
            r3_w    <= r2_w;
            r3_x    <= r2_x;

            r4_lim    <= 49'(r3_unit[32:0]) * 49'(r_thr);
            r4_scaled <= 50'(r3_test) <<< 16;
            r4_zero   <= (r3_unit == '0);
            r4_a2     <= abs_ha[32:1];
            r4_b2     <= abs_hb[32:1];
            r4_test   <= r3_test;
            r4_ha     <= r3_ha;
            r4_hb     <= r3_hb;
            r4_bb     <= r3_bb;
            r4_ba     <= r3_ba;
            r4_w      <= r3_w;
            r4_x      <= r3_x;

            r5_sts  <= n5_sts;
            r5_a2sq <= 64'(r4_a2) * 64'(r4_a2);
            r5_b2sq <= 64'(r4_b2) * 64'(r4_b2);
            r5_test <= r4_test;
            r5_ha   <= r4_ha;
            r5_hb   <= r4_hb;
            r5_bb   <= r4_bb;
            r5_ba   <= r4_ba;
            r5_w    <= r4_w;
            r5_x    <= r4_x;

            r_sv[0] <= r5_a2sq + r5_b2sq;
            r_sr[0] <= '0;
            r_st[0] <= r5_test;
        end
    end

    // restoring square root, two radicand bits per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = r_sr[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_sv[k] >= trial) begin
                    r_sv[k+1] <= r_sv[k] - trial;
                    r_sr[k+1] <= (r_sr[k] >> 1) + BIT;
                end else begin
                    r_sv[k+1] <= r_sv[k];
                    r_sr[k+1] <= r_sr[k] >> 1;
                end
                r_st[k+1] <= r_st[k];
            end
        end
    end

    assign pole5 = (r5_sts == POLE_NORTH) || (r5_sts == POLE_SOUTH);

    qte_atan2 #(.STAGES(CORDIC_STAGES)) u_bank (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (QTE_AW'(r5_bb)),
        .i_x     (QTE_AW'(r5_ba)),
        .o_angle (bank_ang)
    );

    // heading unit also serves 2*atan2(x, w) at the poles
    qte_atan2 #(.STAGES(CORDIC_STAGES)) u_head (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (pole5 ? QTE_AW'(r5_x) : QTE_AW'(r5_hb)),
        .i_x     (pole5 ? QTE_AW'(r5_w) : QTE_AW'(r5_ha)),
        .o_angle (head_ang)
    );

    qte_atan2 #(.STAGES(CORDIC_STAGES)) u_att (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (QTE_AW'(r_st[SQRT_STEPS])),
        .i_x     (signed'(QTE_AW'(r_sr[SQRT_STEPS][31:0]))),
        .o_angle (att_ang)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sts_line[1]  <= r5_sts;
            r_bank_line[1] <= bank_ang;
            r_head_line[1] <= head_ang;
            for (int i = 2; i <= DLY + LAT_CORDIC; i++) r_sts_line[i] <= r_sts_line[i-1];
            for (int i = 2; i <= DLY; i++) begin
                r_bank_line[i] <= r_bank_line[i-1];
                r_head_line[i] <= r_head_line[i-1];
            end
        end
    end

    always_comb begin
        sts_out = r_sts_line[DLY+LAT_CORDIC];
        twice   = r_head_line[DLY] << 1;
        att16   = signed'(qte_angle_out(att_ang));
        if (att16 > QTE_HALF_PI)     att16 = QTE_HALF_PI;
        if (att16 < QTE_NEG_HALF_PI) att16 = QTE_NEG_HALF_PI;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.pole_status <= sts_out;
            unique case (sts_out)
                POLE_ZERO: begin
                    r_out.bank_angle     <= '0;
                    r_out.heading_angle  <= '0;
                    r_out.attitude_angle <= '0;
                end
                POLE_NORTH: begin
                    r_out.bank_angle     <= '0;
                    r_out.heading_angle  <= signed'(qte_angle_out(twice));
                    r_out.attitude_angle <= QTE_HALF_PI;
                end
                POLE_SOUTH: begin
                    r_out.bank_angle     <= '0;
                    r_out.heading_angle  <= signed'(qte_angle_out(32'd0 - twice));
                    r_out.attitude_angle <= QTE_NEG_HALF_PI;
                end
                default: begin
                    r_out.bank_angle     <= signed'(qte_angle_out(r_bank_line[DLY]));
                    r_out.heading_angle  <= signed'(qte_angle_out(r_head_line[DLY]));
                    r_out.attitude_angle <= att16;
                end
            endcase
        end
    end

    a_att_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.attitude_angle <= QTE_HALF_PI) &&
                        (o_out_data.attitude_angle >= QTE_NEG_HALF_PI))
        else $error("attitude outside half pi");

    a_pole_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.pole_status == POLE_NORTH ||
                        o_out_data.pole_status == POLE_SOUTH)
        |-> o_out_data.bank_angle == 16'sd0 &&
            (o_out_data.attitude_angle == QTE_HALF_PI ||
             o_out_data.attitude_angle == QTE_NEG_HALF_PI))
        else $error("pole result with bank or attitude off");

    a_zero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pole_status == POLE_ZERO
        |-> o_out_data.bank_angle == 16'sd0 && o_out_data.heading_angle == 16'sd0 &&
            o_out_data.attitude_angle == 16'sd0)
        else $error("zero quaternion with nonzero angle");

endmodule
